// ===== design/aarm_pkg.sv =====
// Shared types, constants and helper functions for the axis-angle rotation matrix block.
// Used by aarm_cordic_cell, aarm_matrix and axis_angle_rotation_matrix. No dependencies.
`default_nettype none

package aarm_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_COUNT    = 24;
  localparam int NUM_CELLS     = (CORDIC_STAGES > ATAN_COUNT) ? ATAN_COUNT : CORDIC_STAGES;

  localparam int CW = 34;  // CORDIC datapath width, Q30 with headroom

  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [15:0]   Q14_ONE         = 16'sd16384;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 flip;
    logic signed [15:0]   ax;
    logic signed [15:0]   ay;
    logic signed [15:0]   az;
  } cord_t;

  // atan(2^-i), scaled so that 2^32 is a full turn.
  function automatic logic signed [CW-1:0] atan_val(input logic [4:0] idx);
    logic signed [CW-1:0] v;
    case (idx)
      5'd0:    v = 34'sd536870912;
      5'd1:    v = 34'sd316933406;
      5'd2:    v = 34'sd167458907;
      5'd3:    v = 34'sd85004756;
      5'd4:    v = 34'sd42667331;
      5'd5:    v = 34'sd21354465;
      5'd6:    v = 34'sd10679838;
      5'd7:    v = 34'sd5340245;
      5'd8:    v = 34'sd2670163;
      5'd9:    v = 34'sd1335087;
      5'd10:   v = 34'sd667544;
      5'd11:   v = 34'sd333772;
      5'd12:   v = 34'sd166886;
      5'd13:   v = 34'sd83443;
      5'd14:   v = 34'sd41721;
      5'd15:   v = 34'sd20860;
      5'd16:   v = 34'sd10430;
      5'd17:   v = 34'sd5215;
      5'd18:   v = 34'sd2607;
      5'd19:   v = 34'sd1303;
      5'd20:   v = 34'sd651;
      5'd21:   v = 34'sd325;
      5'd22:   v = 34'sd162;
      5'd23:   v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round a Q42 sum to Q14 (floor of sum + half) and saturate to +-1.0.
  function automatic logic signed [15:0] round_sat(input logic signed [55:0] sum);
    logic signed [55:0] r;
    logic signed [27:0] q;
    logic signed [15:0] res;
    r = (sum + 56'sd134217728) >>> 28;
    q = r[27:0];
    if (q > 28'sd16384) begin
      res = Q14_ONE;
    end else if (q < -28'sd16384) begin
      res = -Q14_ONE;
    end else begin
      res = q[15:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== design/aarm_cordic_cell.sv =====
// One CORDIC rotation cell with its own valid flag and stall-aware load.
// Depends on aarm_pkg for cord_t and the arctangent table.
`default_nettype none

module aarm_cordic_cell import aarm_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [4:0] stage_i,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire cord_t      data_i,
  output logic            valid_o,
  input  wire logic       ready_i,
  output cord_t           data_o
);

  logic  valid_q;
  cord_t data_q, data_d;
  logic signed [CW-1:0] dx, dy, at;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    dx     = data_i.y >>> stage_i;
    dy     = data_i.x >>> stage_i;
    at     = atan_val(stage_i);
    data_d = data_i;
    if (!data_i.z[CW-1]) begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - at;
    end else begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

// ===== design/aarm_matrix.sv =====
// Matrix back end: sine/cosine rounding, product pipeline and final round/saturate.
// Depends on aarm_pkg for cord_t and round_sat.
`default_nettype none

module aarm_matrix import aarm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire cord_t       data_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output logic signed [15:0] m_o [9]
);

  logic [3:0] v_q;
  logic [4:0] en;

  // Stage 0: c, s, t and the axis.
  logic signed [17:0] c0_q, s0_q;
  logic signed [18:0] t0_q;
  logic signed [15:0] ax0_q, ay0_q, az0_q;
  // Stage 1: t*a and s*a.
  logic signed [34:0] tx1_q, ty1_q, tz1_q;
  logic signed [33:0] sx1_q, sy1_q, sz1_q;
  logic signed [17:0] c1_q;
  logic signed [15:0] ax1_q, ay1_q, az1_q;
  // Stage 2: t*a*b.
  logic signed [50:0] txx_q, txy_q, txz_q, tyy_q, tyz_q, tzz_q;
  logic signed [33:0] sx2_q, sy2_q, sz2_q;
  logic signed [17:0] c2_q;
  // Stage 3: results.
  logic signed [15:0] m_q [9];

  logic signed [CW-1:0] cx, cy;
  logic signed [CW:0]   cr, sr;
  logic signed [55:0]   cl, sxl, syl, szl;

  assign en[4] = ready_i;
  for (genvar k = 0; k < 4; k++) begin : g_en
    assign en[k] = !v_q[k] || en[k+1];
  end

  assign cx = data_i.flip ? -data_i.x : data_i.x;
  assign cy = data_i.flip ? -data_i.y : data_i.y;
  assign cr = (35'(cx) + 35'sd32768) >>> 16;
  assign sr = (35'(cy) + 35'sd32768) >>> 16;

  assign cl  = 56'(c2_q) <<< 28;
  assign sxl = 56'(sx2_q) <<< 14;
  assign syl = 56'(sy2_q) <<< 14;
  assign szl = 56'(sz2_q) <<< 14;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && valid_i) begin
      c0_q  <= cr[17:0];
      s0_q  <= sr[17:0];
      t0_q  <= 19'sd16384 - 19'($signed(cr[17:0]));
      ax0_q <= data_i.ax;
      ay0_q <= data_i.ay;
      az0_q <= data_i.az;
    end
    if (en[1] && v_q[0]) begin
      tx1_q <= 35'(t0_q * ax0_q);
      ty1_q <= 35'(t0_q * ay0_q);
      tz1_q <= 35'(t0_q * az0_q);
      sx1_q <= 34'(s0_q * ax0_q);
      sy1_q <= 34'(s0_q * ay0_q);
      sz1_q <= 34'(s0_q * az0_q);
      c1_q  <= c0_q;
      ax1_q <= ax0_q;
      ay1_q <= ay0_q;
      az1_q <= az0_q;
    end
    if (en[2] && v_q[1]) begin
      txx_q <= 51'(tx1_q * ax1_q);
      txy_q <= 51'(tx1_q * ay1_q);
      txz_q <= 51'(tx1_q * az1_q);
      tyy_q <= 51'(ty1_q * ay1_q);
      tyz_q <= 51'(ty1_q * az1_q);
      tzz_q <= 51'(tz1_q * az1_q);
      sx2_q <= sx1_q;
      sy2_q <= sy1_q;
      sz2_q <= sz1_q;
      c2_q  <= c1_q;
    end
    if (en[3] && v_q[2]) begin
      m_q[0] <= round_sat(56'(txx_q) + cl);
      m_q[1] <= round_sat(56'(txy_q) - szl);
      m_q[2] <= round_sat(56'(txz_q) + syl);
      m_q[3] <= round_sat(56'(txy_q) + szl);
      m_q[4] <= round_sat(56'(tyy_q) + cl);
      m_q[5] <= round_sat(56'(tyz_q) - sxl);
      m_q[6] <= round_sat(56'(txz_q) - syl);
      m_q[7] <= round_sat(56'(tyz_q) + sxl);
      m_q[8] <= round_sat(56'(tzz_q) + cl);
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[3];
  assign m_o     = m_q;

endmodule

`default_nettype wire

// ===== design/axis_angle_rotation_matrix.sv =====
// Top level of the axis-angle (Rodrigues) rotation matrix block.
// Depends on aarm_pkg, aarm_cordic_cell and aarm_matrix.
//
// Usage: an input transfer carries a Q2.14 axis (axis_x/y/z) and a 16-bit
// binary angle (65536 = full turn). One output transfer returns the nine
// Q2.14 entries m00..m22 of the 3x3 rotation matrix, each saturated to +-1.0.
// Both channels use valid/ready.
// Each CORDIC cell is a pipeline register, followed by the rounding register,
// two multiplier stages and the final round/saturate register.
// Throughput is one transfer per cycle; every stage holds its own valid
// flag, so the chain accepts a new item every cycle while it is not full.
// When the receiver stalls, items pile up behind the output register and
// bubbles are squeezed out; in_ready_o drops only once every stage is full.
// Reset clears all valid flags; the data registers are not reset.
`default_nettype none

module axis_angle_rotation_matrix import aarm_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [15:0] axis_x_i,
  input  wire logic [15:0] axis_y_i,
  input  wire logic [15:0] axis_z_i,
  input  wire logic [15:0] turn_angle_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      m00_o,
  output logic [15:0]      m01_o,
  output logic [15:0]      m02_o,
  output logic [15:0]      m10_o,
  output logic [15:0]      m11_o,
  output logic [15:0]      m12_o,
  output logic [15:0]      m20_o,
  output logic [15:0]      m21_o,
  output logic [15:0]      m22_o
);

  cord_t chain_data [NUM_CELLS+1];
  logic  chain_valid [NUM_CELLS+1];
  logic  chain_ready [NUM_CELLS+1];
  logic  fold;
  logic [15:0] ang;
  logic signed [15:0] m [9];

  // Angles in the left half-plane are turned by half a turn; the sign of
  // sine and cosine is restored after the CORDIC.
  assign fold = turn_angle_i[15] ^ turn_angle_i[14];
  assign ang  = fold ? {~turn_angle_i[15], turn_angle_i[14:0]} : turn_angle_i;

  always_comb begin
    chain_data[0].x    = CORDIC_GAIN_Q30;
    chain_data[0].y    = '0;
    chain_data[0].z    = {{2{ang[15]}}, ang, 16'b0};
    chain_data[0].flip = fold;
    chain_data[0].ax   = axis_x_i;
    chain_data[0].ay   = axis_y_i;
    chain_data[0].az   = axis_z_i;
  end
  assign chain_valid[0] = in_valid_i;
  assign in_ready_o     = chain_ready[0];

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    aarm_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (5'(k)),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .data_i  (chain_data[k]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1]),
      .data_o  (chain_data[k+1])
    );
  end

  aarm_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_valid[NUM_CELLS]),
    .ready_o (chain_ready[NUM_CELLS]),
    .data_i  (chain_data[NUM_CELLS]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .m_o     (m)
  );

  assign m00_o = m[0];
  assign m01_o = m[1];
  assign m02_o = m[2];
  assign m10_o = m[3];
  assign m11_o = m[4];
  assign m12_o = m[5];
  assign m20_o = m[6];
  assign m21_o = m[7];
  assign m22_o = m[8];

  // The input can only stall when the whole chain is backed up by the receiver.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a receiver stall");

  a_diag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(m00_o) <= 16'sd16384 && $signed(m00_o) >= -16'sd16384 &&
                     $signed(m11_o) <= 16'sd16384 && $signed(m11_o) >= -16'sd16384))
    else $error("diagonal entry outside saturation range");

  a_offdiag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(m01_o) <= 16'sd16384 && $signed(m01_o) >= -16'sd16384 &&
                     $signed(m10_o) <= 16'sd16384 && $signed(m10_o) >= -16'sd16384))
    else $error("off-diagonal entry outside saturation range");

endmodule

`default_nettype wire

// ===== test/tb_axis_angle_rotation_matrix.sv =====
// Testbench for axis_angle_rotation_matrix: drives axis/angle transfers and checks
// each returned 3x3 matrix against a behavioral Rodrigues/CORDIC predictor.
// Depends on aarm_pkg and the axis_angle_rotation_matrix RTL.
`timescale 1ns / 1ps

module tb_axis_angle_rotation_matrix;
  import aarm_pkg::*;

  localparam int LATENCY     = NUM_CELLS + 4;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } matrix_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic [15:0] axis_x_i = '0, axis_y_i = '0, axis_z_i = '0, turn_angle_i = '0;
  logic in_ready_o, out_valid_o;
  logic [15:0] m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o;

  matrix_t pending_matrices[$];
  int  error_count = 0;
  int  cycle_count = 0;
  bit  sink_hold   = 1'b0;
  bit  sink_busy   = 1'b1;
  bit  src_busy    = 1'b1;

  axis_angle_rotation_matrix dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic logic [15:0] round_entry(longint tab, longint lin);
    longint r;
    r = floor_shift(tab + lin * 16384 + (longint'(1) << 27), 28);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function automatic matrix_t rotation_matrix(logic [15:0] ax, logic [15:0] ay,
                                              logic [15:0] az, logic [15:0] ang);
    longint x, y, z, a, cx, cy, cz, dx, dy, c, s, t;
    longint atan_q32[24];
    bit flip;
    matrix_t m;
    atan_q32 = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                 10679838, 5340245, 2670163, 1335087, 667544, 333772,
                 166886, 83443, 41721, 20860, 10430, 5215,
                 2607, 1303, 651, 325, 162, 81};
    x = longint'($signed(ax));
    y = longint'($signed(ay));
    z = longint'($signed(az));
    a = longint'(ang);
    flip = 1'b0;
    // Fold the angle into the CORDIC's convergence range.
    if (a >= 16384 && a < 49152) begin
      a -= 32768;
      flip = 1'b1;
    end else if (a >= 49152) begin
      a -= 65536;
    end
    cx = 652032874;
    cy = 0;
    cz = a * 65536;
    for (int i = 0; i < NUM_CELLS; i++) begin
      dx = floor_shift(cy, i);
      dy = floor_shift(cx, i);
      if (cz >= 0) begin
        cx -= dx; cy += dy; cz -= atan_q32[i];
      end else begin
        cx += dx; cy -= dy; cz += atan_q32[i];
      end
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    c = floor_shift(cx + 32768, 16);
    s = floor_shift(cy + 32768, 16);
    t = 16384 - c;
    m.m00 = round_entry(t * x * x, c * 16384);
    m.m01 = round_entry(t * x * y, -s * z);
    m.m02 = round_entry(t * x * z, s * y);
    m.m10 = round_entry(t * x * y, s * z);
    m.m11 = round_entry(t * y * y, c * 16384);
    m.m12 = round_entry(t * y * z, -s * x);
    m.m20 = round_entry(t * x * z, -s * y);
    m.m21 = round_entry(t * y * z, s * x);
    m.m22 = round_entry(t * z * z, c * 16384);
    return m;
  endfunction

  // Receiver: random stalls, always ready while sink_busy is clear, or a long hold-off while sink_hold is set.
  always @(posedge clk_i) begin
    if (sink_hold) begin
      out_ready_i <= 1'b0;
    end else if (sink_busy) begin
      out_ready_i <= ($urandom_range(0, 99) >= 20);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Checks each output transfer against the oldest predicted matrix.
  always @(posedge clk_i) begin
    matrix_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o};
      if (pending_matrices.size() == 0) begin
        $display("%0t: unexpected matrix %h", $time, got);
        error_count++;
      end else begin
        want = pending_matrices.pop_front();
        for (int k = 8; k >= 0; k--) begin
          if (got[k*16 +: 16] != want[k*16 +: 16]) begin
            $display("%0t: entry %0d expected %0d actual %0d", $time, 8 - k,
                     $signed(want[k*16 +: 16]), $signed(got[k*16 +: 16]));
            error_count++;
          end
        end
      end
    end
  end

  // Valid stays high between back-to-back transfers; it drops only while idling.
  task automatic send_rotation(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                               logic [15:0] ang);
    while (src_busy && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    axis_x_i     <= ax;
    axis_y_i     <= ay;
    axis_z_i     <= az;
    turn_angle_i <= ang;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_matrices.push_back(rotation_matrix(ax, ay, az, ang));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_matrices.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [15:0] random_axis();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic test_corner_angles();
    logic [15:0] angles[8] = '{16'd0, 16'd16383, 16'd16384, 16'd32768,
                               16'd49151, 16'd49152, 16'd65535, 16'd8192};
    foreach (angles[i]) send_rotation(16'sd16384, 16'sd0, 16'sd0, angles[i]);
    send_rotation(16'sd0, 16'sd16384, 16'sd0, 16'd12345);
    send_rotation(16'sd0, 16'sd0, -16'sd16384, 16'd40000);
    send_rotation(16'sd9459, 16'sd9459, 16'sd9459, 16'd21845);
  endtask

  // Axes off the unit sphere drive entries into saturation.
  task automatic test_saturation();
    send_rotation(16'h7fff, 16'h7fff, 16'h7fff, 16'd32768);
    send_rotation(16'h8000, 16'h8000, 16'h8000, 16'd16384);
    send_rotation(16'h7fff, 16'h8000, 16'hffff, 16'd49152);
    send_rotation(16'h8000, 16'h7fff, 16'h0001, 16'd65535);
    send_rotation(16'h5555, 16'haaaa, 16'h7fff, 16'd5461);
    send_rotation(16'haaaa, 16'h5555, 16'h8000, 16'd43690);
  endtask

  task automatic test_random(int count);
    logic [15:0] ax, ay, az;
    for (int n = 0; n < count; n++) begin
      src_busy  = !(n >= 300 && n < 500);
      sink_busy = !(n >= 300 && n < 500);
      if ($urandom_range(0, 9) < 8) begin
        ax = random_axis(); ay = random_axis(); az = random_axis();
      end else begin
        ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
      end
      send_rotation(ax, ay, az, 16'($urandom));
    end
    src_busy  = 1'b1;
    sink_busy = 1'b1;
  endtask

  // Receiver holds off long enough for the pipeline to fill and stall input.
  task automatic test_backpressure();
    fork
      begin
        sink_hold = 1'b1;
        repeat (3 * LATENCY) @(posedge clk_i);
        sink_hold = 1'b0;
      end
      for (int n = 0; n < 2 * LATENCY; n++) begin
        send_rotation(random_axis(), random_axis(), random_axis(), 16'($urandom));
      end
    join
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_angles();
    test_saturation();
    wait_drained();
    test_backpressure();
    test_random(1550);
    wait_drained();
    repeat (LATENCY + 5) @(posedge clk_i);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
